// File: design/tcbpa_pkg.sv
// Shared types and constants for the two-class block pool allocator.
package tcbpa_pkg;

  localparam int unsigned SIZE_W = 13;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned ADDR_W = 17;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE = 1'b1;

  typedef enum logic [1:0] {
    CFG_SMALL_SIZE  = 2'd0,
    CFG_SMALL_COUNT = 2'd1,
    CFG_LARGE_SIZE  = 2'd2,
    CFG_LARGE_COUNT = 2'd3
  } cfg_reg_e;

  localparam logic [SIZE_W-1:0] SMALL_SIZE_RST = 13'd32;
  localparam logic [COUNT_W-1:0] SMALL_COUNT_RST = 6'd10;
  localparam logic [SIZE_W-1:0] LARGE_SIZE_RST = 13'd64;
  localparam logic [COUNT_W-1:0] LARGE_COUNT_RST = 6'd20;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] request_bytes;
    logic [ADDR_W-1:0] release_address;
  } req_t;

  typedef struct packed {
    logic              success;
    logic [ADDR_W-1:0] granted_address;
    logic [SIZE_W-1:0] granted_size;
  } rsp_t;

  typedef struct packed {
    logic [SIZE_W-1:0] small_size;
    logic [SIZE_W-1:0] large_size;
  } cfg_sizes_t;

endpackage

// File: design/tcbpa_cfg_regs.sv
// Configuration registers and block count clamping for the pool allocator.
module tcbpa_cfg_regs #(
  parameter int unsigned MAX_BLOCKS = 32,
  parameter int unsigned CNT_W = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  tcbpa_pkg::cfg_reg_e        cfg_index_i,
  input  logic [tcbpa_pkg::SIZE_W-1:0] cfg_data_i,
  output tcbpa_pkg::cfg_sizes_t      sizes_o,
  output logic [CNT_W-1:0]           small_total_o,
  output logic [CNT_W-1:0]           all_total_o
);

  localparam int unsigned CMP_W = (CNT_W > tcbpa_pkg::COUNT_W) ? CNT_W : tcbpa_pkg::COUNT_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_BLOCKS);

  logic [tcbpa_pkg::SIZE_W-1:0]  small_size_q, large_size_q;
  logic [tcbpa_pkg::COUNT_W-1:0] small_count_q, large_count_q;

  logic [CMP_W-1:0] sc_ext, lc_ext, ns_cmp, room_cmp, nl_cmp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_size_q  <= tcbpa_pkg::SMALL_SIZE_RST;
      small_count_q <= tcbpa_pkg::SMALL_COUNT_RST;
      large_size_q  <= tcbpa_pkg::LARGE_SIZE_RST;
      large_count_q <= tcbpa_pkg::LARGE_COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tcbpa_pkg::CFG_SMALL_SIZE:  small_size_q  <= cfg_data_i;
        tcbpa_pkg::CFG_SMALL_COUNT: small_count_q <= cfg_data_i[tcbpa_pkg::COUNT_W-1:0];
        tcbpa_pkg::CFG_LARGE_SIZE:  large_size_q  <= cfg_data_i;
        tcbpa_pkg::CFG_LARGE_COUNT: large_count_q <= cfg_data_i[tcbpa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // cut counts to the pool capacity, small class first
  always_comb begin
    sc_ext   = CMP_W'(small_count_q);
    lc_ext   = CMP_W'(large_count_q);
    ns_cmp   = (sc_ext > MAX_CMP) ? MAX_CMP : sc_ext;
    room_cmp = MAX_CMP - ns_cmp;
    nl_cmp   = (lc_ext > room_cmp) ? room_cmp : lc_ext;
  end

  assign small_total_o      = CNT_W'(ns_cmp);
  assign all_total_o        = CNT_W'(ns_cmp + nl_cmp);
  assign sizes_o.small_size = small_size_q;
  assign sizes_o.large_size = large_size_q;

endmodule

// File: design/tcbpa_scan.sv
// Block scan sequencer: in-use flags, running address and the shared compare unit.
module tcbpa_scan #(
  parameter int unsigned MAX_BLOCKS = 32,
  parameter int unsigned CNT_W = $clog2(MAX_BLOCKS + 1),
  parameter int unsigned IDX_W = $clog2(MAX_BLOCKS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  tcbpa_pkg::req_t       req_i,
  input  tcbpa_pkg::cfg_sizes_t sizes_i,
  input  logic [CNT_W-1:0]      small_total_i,
  input  logic [CNT_W-1:0]      all_total_i,
  output logic                  busy_o,
  output logic                  done_o,
  output tcbpa_pkg::rsp_t       rsp_o
);

  tcbpa_pkg::state_e state_q, state_d;
  tcbpa_pkg::req_t   req_q;
  tcbpa_pkg::rsp_t   rsp_q, rsp_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [tcbpa_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [MAX_BLOCKS-1:0] in_use_q, in_use_d;
  logic done_q, done_d;

  logic [tcbpa_pkg::SIZE_W-1:0] blk_size;
  logic blk_used, hit, at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tcbpa_pkg::ST_IDLE;
      in_use_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      in_use_q <= in_use_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    addr_q <= addr_d;
    rsp_q  <= rsp_d;
    if (start_i && state_q == tcbpa_pkg::ST_IDLE) begin
      req_q <= req_i;
    end
  end

  always_comb begin
    blk_size = (idx_q < small_total_i) ? sizes_i.small_size : sizes_i.large_size;
    blk_used = in_use_q[idx_q[IDX_W-1:0]];
    at_end   = (idx_q >= all_total_i);
    if (req_q.kind == tcbpa_pkg::KIND_ALLOC) begin
      hit = !blk_used && (blk_size >= req_q.request_bytes);
    end else begin
      hit = blk_used && (addr_q == req_q.release_address);
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    addr_d   = addr_q;
    rsp_d    = rsp_q;
    in_use_d = in_use_q;
    done_d   = 1'b0;
    unique case (state_q)
      tcbpa_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = tcbpa_pkg::ST_SCAN;
          idx_d   = '0;
          addr_d  = '0;
        end
      end
      tcbpa_pkg::ST_SCAN: begin
        if (at_end) begin
          rsp_d   = '0;
          done_d  = 1'b1;
          state_d = tcbpa_pkg::ST_IDLE;
        end else if (hit) begin
          rsp_d         = '0;
          rsp_d.success = 1'b1;
          in_use_d[idx_q[IDX_W-1:0]] = (req_q.kind == tcbpa_pkg::KIND_ALLOC);
          if (req_q.kind == tcbpa_pkg::KIND_ALLOC) begin
            rsp_d.granted_address = addr_q;
            rsp_d.granted_size    = blk_size;
          end
          done_d  = 1'b1;
          state_d = tcbpa_pkg::ST_IDLE;
        end else begin
          // address wraps modulo the 17-bit pool space
          addr_d = addr_q + tcbpa_pkg::ADDR_W'(blk_size);
          idx_d  = idx_q + CNT_W'(1);
        end
      end
      default: state_d = tcbpa_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q == tcbpa_pkg::ST_SCAN);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: design/two_class_block_pool_allocator.sv
// Two-class fixed-size block pool allocator, one block examined per cycle.
// done_o is a registered strobe raised when the scan ends on a matching block or runs out
//   (a failed request passes every configured block, at most MAX_BLOCKS).
// One request is served at a time; the single block compare/address unit
//   steps through blocks in order and busy stays high for the whole scan.
// Reset clears all in-use flags at once and loads the default class sizes and counts.
module two_class_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  tcbpa_pkg::req_t              req_i,
  output logic                         done_o,
  output tcbpa_pkg::rsp_t              rsp_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [tcbpa_pkg::SIZE_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  tcbpa_pkg::cfg_sizes_t sizes;
  logic [CNT_W-1:0] small_total, all_total;

  // layout must not move under a scan in progress
  assign cfg_ready_o = ~busy;

  tcbpa_cfg_regs #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .CNT_W     (CNT_W)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i & cfg_ready_o),
    .cfg_index_i  (tcbpa_pkg::cfg_reg_e'(cfg_index_i)),
    .cfg_data_i   (cfg_data_i),
    .sizes_o      (sizes),
    .small_total_o(small_total),
    .all_total_o  (all_total)
  );

  tcbpa_scan #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .CNT_W     (CNT_W),
    .IDX_W     ($clog2(MAX_BLOCKS))
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .req_i        (req_i),
    .sizes_i      (sizes),
    .small_total_i(small_total),
    .all_total_i  (all_total),
    .busy_o       (busy),
    .done_o       (done_o),
    .rsp_o        (rsp_o)
  );

endmodule
